// File: src/rgb_median_filter_3x3_assert.svh
// assertion macros shared by the checker files of the median filter
// no dependencies; the caller supplies clock, reset and property terms
`ifndef RGB_MEDIAN_FILTER_3X3_ASSERT_SVH
`define RGB_MEDIAN_FILTER_3X3_ASSERT_SVH

// same-cycle implication, muted while reset is low
`define RMF_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, muted while reset is low
`define RMF_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/rmf_pkg.sv
// shared types and constants of the rgb 3x3 median filter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rmf_pkg;

    localparam int CH_W          = 8;
    localparam int PIX_W         = 3 * CH_W;
    localparam int WIN_N         = 9;
    localparam int CFG_WIDTH_W   = 12;
    localparam int CFG_HEIGHT_W  = 13;
    localparam int ROW_W         = 12;
    localparam int CCOL_W        = 11;
    localparam int CROW_W        = 12;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam int DEF_MAX_WIDTH = 2048;
    localparam int OUT_DEPTH     = 8;

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

    // register index, taken from paddr[2]
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] blue_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] red_in;
        logic            frame_start;
    } pix_word_t;

    typedef struct packed {
        logic [CH_W-1:0]   blue_median;
        logic [CH_W-1:0]   green_median;
        logic [CH_W-1:0]   red_median;
        logic [CCOL_W-1:0] centre_column;
        logic [CROW_W-1:0] centre_row;
    } res_word_t;

    // per-word tag carried alongside the pixel data
    typedef struct packed {
        logic              produce;
        logic [CCOL_W-1:0] ccol;
        logic [CROW_W-1:0] crow;
    } rmf_meta_t;

    // window taps: 0..2 top row, 3..5 middle, 6..8 bottom; blue in the low byte
    typedef logic [WIN_N-1:0][PIX_W-1:0] window_t;

endpackage

`default_nettype wire

// File: src/rmf_line_buf.sv
// two-line buffer in one 48-bit memory plus the 3x3 window shift register
// depends on rmf_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmf_line_buf
    import rmf_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         acc,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] col,
    input  wire logic [PIX_W-1:0]             pix,
    input  wire rmf_meta_t                    meta,
    output      window_t                      win,
    output      logic                         win_valid,
    output      rmf_meta_t                    win_meta
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    // entry holds {two rows up, one row up}
    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rdata_reg;

    logic               s1_valid_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [PIX_W-1:0]   s1_pix_reg;
    rmf_meta_t          s1_meta_reg;
    logic               s1_fwd_reg;
    logic [2*PIX_W-1:0] s1_fwd_data_reg;

    logic [2*PIX_W-1:0] s1_rd;
    logic [PIX_W-1:0]   s1_up;
    logic [PIX_W-1:0]   s1_lo;
    logic [2*PIX_W-1:0] s1_wdata;
    logic               fwd_next;

    window_t            win_reg;
    logic               win_valid_reg;
    rmf_meta_t          win_meta_reg;

    always_comb
    begin
        s1_rd    = s1_fwd_reg ? s1_fwd_data_reg : rdata_reg;
        s1_up    = s1_rd[2*PIX_W-1:PIX_W];
        s1_lo    = s1_rd[PIX_W-1:0];
        s1_wdata = {s1_lo, s1_pix_reg};
        // the write of the word in s1 lands too late for a read of the same column
        fwd_next = s1_valid_reg && (s1_col_reg == col);
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rdata_reg <= mem[col];
        end
        if (s1_valid_reg)
        begin
            mem[s1_col_reg] <= s1_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            win_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= acc;
            win_valid_reg <= s1_valid_reg && s1_meta_reg.produce;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_col_reg      <= col;
            s1_pix_reg      <= pix;
            s1_meta_reg     <= meta;
            s1_fwd_reg      <= fwd_next;
            s1_fwd_data_reg <= s1_wdata;
        end
        if (s1_valid_reg)
        begin
            win_reg[0]   <= win_reg[1];
            win_reg[1]   <= win_reg[2];
            win_reg[2]   <= s1_up;
            win_reg[3]   <= win_reg[4];
            win_reg[4]   <= win_reg[5];
            win_reg[5]   <= s1_lo;
            win_reg[6]   <= win_reg[7];
            win_reg[7]   <= win_reg[8];
            win_reg[8]   <= s1_pix_reg;
            win_meta_reg <= s1_meta_reg;
        end
    end

    assign win       = win_reg;
    assign win_valid = win_valid_reg;
    assign win_meta  = win_meta_reg;

endmodule

`default_nettype wire

// File: src/rmf_median.sv
// three-stage median-of-nine pipeline for the blue, green and red channels
// depends on rmf_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmf_median
    import rmf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire window_t   win,
    input  wire logic      win_valid,
    input  wire rmf_meta_t win_meta,
    output      logic      res_valid,
    output      res_word_t res_data
);

    function automatic logic [CH_W-1:0] min2(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [CH_W-1:0] max2(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [CH_W-1:0] med3(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
                                             input logic [CH_W-1:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // rank 0 lowest, rank 2 highest
    function automatic logic [2:0][CH_W-1:0] sort3(input logic [CH_W-1:0] a,
                                                   input logic [CH_W-1:0] b,
                                                   input logic [CH_W-1:0] c);
        logic [CH_W-1:0]       lo1;
        logic [CH_W-1:0]       hi1;
        logic [CH_W-1:0]       t;
        logic [2:0][CH_W-1:0]  s;
        lo1  = min2(a, b);
        hi1  = max2(a, b);
        t    = max2(lo1, c);
        s[0] = min2(lo1, c);
        s[1] = min2(hi1, t);
        s[2] = max2(hi1, t);
        return s;
    endfunction

    // [channel][row][rank]
    logic [2:0][2:0][2:0][CH_W-1:0] sa_next;
    logic [2:0][2:0][2:0][CH_W-1:0] sa_reg;
    logic                           sa_valid_reg;
    rmf_meta_t                      sa_meta_reg;

    // [channel][max of lows, median of mids, min of highs]
    logic [2:0][2:0][CH_W-1:0]      sb_next;
    logic [2:0][2:0][CH_W-1:0]      sb_reg;
    logic                           sb_valid_reg;
    rmf_meta_t                      sb_meta_reg;

    logic [2:0][CH_W-1:0]           med_next;
    res_word_t                      res_reg;
    logic                           res_valid_reg;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                sa_next[ch][r] = sort3(win[3*r][CH_W*ch +: CH_W],
                                       win[3*r+1][CH_W*ch +: CH_W],
                                       win[3*r+2][CH_W*ch +: CH_W]);
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            sb_next[ch][0] = max2(max2(sa_reg[ch][0][0], sa_reg[ch][1][0]), sa_reg[ch][2][0]);
            sb_next[ch][1] = med3(sa_reg[ch][0][1], sa_reg[ch][1][1], sa_reg[ch][2][1]);
            sb_next[ch][2] = min2(min2(sa_reg[ch][0][2], sa_reg[ch][1][2]), sa_reg[ch][2][2]);
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            med_next[ch] = med3(sb_reg[ch][0], sb_reg[ch][1], sb_reg[ch][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_valid_reg  <= 1'b0;
            sb_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            sa_valid_reg  <= win_valid;
            sb_valid_reg  <= sa_valid_reg;
            res_valid_reg <= sb_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sa_reg                <= sa_next;
        sa_meta_reg           <= win_meta;
        sb_reg                <= sb_next;
        sb_meta_reg           <= sa_meta_reg;
        res_reg.blue_median   <= med_next[0];
        res_reg.green_median  <= med_next[1];
        res_reg.red_median    <= med_next[2];
        res_reg.centre_column <= sb_meta_reg.ccol;
        res_reg.centre_row    <= sb_meta_reg.crow;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

`default_nettype wire

// File: src/rmf_out_fifo.sv
// small result queue between the median pipeline and the output channel
// depends on rmf_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmf_out_fifo
    import rmf_pkg::*;
#(
    parameter int DEPTH = OUT_DEPTH
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr_en,
    input  wire res_word_t wr_data,
    output      logic      out_valid,
    input  wire logic      out_stall,
    output      res_word_t out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    res_word_t        q_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             pop;

    assign pop = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CNT_W'(wr_en) - CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign out_valid = (cnt_reg != '0);
    assign out_data  = q_mem[rd_ptr_reg];

endmodule

`default_nettype wire

// File: src/rgb_median_filter_3x3.sv
// top level of the rgb 3x3 median filter: config registers, raster position, result credit
// depends on rmf_pkg, rmf_line_buf, rmf_median, rmf_out_fifo
`timescale 1ns / 1ps
`default_nettype none

// streaming 3x3 median filter on raster-order rgb pixels, one pixel word per clock
// sustained while the input is not stalled; a result word for the pixel that
// completes its window passes the line memory read (which lands on the accepting
// edge), the window shift, the median pipeline and the output buffer. the two
// previous lines live in a single MAX_WIDTH x 48 synchronous memory that is read at
// the pixel's column on accept and written back in the following cycle; a pixel that
// hits the same column as the one just before it (frame restart at column 0) takes
// the written data through a bypass.
// results queue in an 8-word output buffer; the input stalls only while eight
// results are queued or in flight, so a stalled output costs nothing until then.
// border pixels give no result. image_width (offset 0x0) and image_height (0x4)
// saturate to 3..MAX_WIDTH and 3..4096; a write to either restarts the position at
// column 0, row 0. the line memory has no reset and no clearing pass: lines that were
// never written read as garbage until the first two rows of a frame have passed.

module rgb_median_filter_3x3
    import rmf_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // apb config port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output      logic [APB_DATA_W-1:0] prdata,
    output      logic                  pready,
    // pixel input
    input  wire logic                  pix_valid,
    output      logic                  pix_stall,
    input  wire pix_word_t             pix_data,
    // result output
    output      logic                  res_valid,
    input  wire logic                  res_stall,
    output      res_word_t             res_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    // compare width wide enough for both the register and MAX_WIDTH itself
    localparam int CMP_W  = (COL_W + 1 > CFG_WIDTH_W) ? COL_W + 1 : CFG_WIDTH_W;
    localparam int CRED_W = $clog2(OUT_DEPTH + 1);

    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    logic                    cfg_wr;

    logic [COL_W-1:0]        col_reg;
    logic [ROW_W-1:0]        row_reg;
    logic [CRED_W-1:0]       cred_reg;

    logic                    acc;
    logic                    res_acc;
    logic [COL_W-1:0]        col_cur;
    logic [ROW_W-1:0]        row_cur;
    logic [CMP_W-1:0]        w_raw;
    logic [CMP_W-1:0]        w_eff;
    logic [CFG_HEIGHT_W-1:0] h_eff;
    logic [CMP_W-1:0]        col_inc;
    logic [ROW_W:0]          row_inc;
    logic                    col_wrap;
    logic [COL_W-1:0]        col_next;
    logic [ROW_W-1:0]        row_next;
    logic [PIX_W-1:0]        pix;
    rmf_meta_t               s0_meta;

    window_t                 win;
    logic                    win_valid;
    rmf_meta_t               win_meta;
    logic                    med_valid;
    res_word_t               med_data;

    // ---------------- config registers ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[CFG_HEIGHT_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- raster position ----------------
    assign acc     = pix_valid && !pix_stall;
    assign res_acc = res_valid && !res_stall;

    always_comb
    begin
        // saturate the programmed size
        w_raw = CMP_W'(width_reg);
        if (w_raw < CMP_W'(3))
        begin
            w_eff = CMP_W'(3);
        end
        else if (w_raw > CMP_W'(MAX_WIDTH))
        begin
            w_eff = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_raw;
        end
        if (height_reg < CFG_HEIGHT_W'(3))
        begin
            h_eff = CFG_HEIGHT_W'(3);
        end
        else if (height_reg > CFG_HEIGHT_W'(4096))
        begin
            h_eff = CFG_HEIGHT_W'(4096);
        end
        else
        begin
            h_eff = height_reg;
        end

        col_cur  = pix_data.frame_start ? '0 : col_reg;
        row_cur  = pix_data.frame_start ? '0 : row_reg;
        col_inc  = CMP_W'(col_cur) + CMP_W'(1);
        row_inc  = {1'b0, row_cur} + 1'b1;
        col_wrap = (col_inc >= w_eff);
        col_next = col_wrap ? '0 : col_inc[COL_W-1:0];
        if (!col_wrap)
        begin
            row_next = row_cur;
        end
        else if (row_inc >= h_eff)
        begin
            row_next = '0;
        end
        else
        begin
            row_next = row_inc[ROW_W-1:0];
        end

        // a result needs two full columns and two full rows behind this pixel
        s0_meta.produce = (col_cur >= COL_W'(2)) && (row_cur >= ROW_W'(2));
        s0_meta.ccol    = CCOL_W'(col_cur - COL_W'(1));
        s0_meta.crow    = CROW_W'(row_cur - ROW_W'(1));
        pix             = {pix_data.red_in, pix_data.green_in, pix_data.blue_in};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_wr)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- result credit ----------------
    // counts results in flight plus results queued, so the queue never overflows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cred_reg <= '0;
        end
        else
        begin
            cred_reg <= cred_reg + CRED_W'(acc && s0_meta.produce) - CRED_W'(res_acc);
        end
    end

    assign pix_stall = (cred_reg >= CRED_W'(OUT_DEPTH));

    // ---------------- datapath ----------------
    rmf_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .col       (col_cur),
        .pix       (pix),
        .meta      (s0_meta),
        .win       (win),
        .win_valid (win_valid),
        .win_meta  (win_meta)
    );

    rmf_median u_median (
        .clk       (clk),
        .rst_n     (rst_n),
        .win       (win),
        .win_valid (win_valid),
        .win_meta  (win_meta),
        .res_valid (med_valid),
        .res_data  (med_data)
    );

    rmf_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (med_valid),
        .wr_data   (med_data),
        .out_valid (res_valid),
        .out_stall (res_stall),
        .out_data  (res_data)
    );

endmodule

`default_nettype wire

// File: src/rmf_checker.sv
// port-level checks of the rgb 3x3 median filter and their bind to the top level
// depends on rmf_pkg and rgb_median_filter_3x3_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_median_filter_3x3_assert.svh"

module rmf_checker
    import rmf_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      pix_valid,
    input wire logic      pix_stall,
    input wire logic      res_valid,
    input wire logic      res_stall,
    input wire res_word_t res_data
);

    // a held result word keeps its value
    `RMF_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid && $stable(res_data), "result word changed while stalled")

    // the queue only drains through a taken word
    `RMF_ASSERT_NOW(a_res_drop, clk, rst_n, $fell(res_valid), $past(!res_stall), "result valid dropped without a transfer")

    // a window centre never lies on the top row
    `RMF_ASSERT_NOW(a_row_inner, clk, rst_n, res_valid, res_data.centre_row != '0, "result on the top border row")

    // credit fills only through an accepted pixel
    `RMF_ASSERT_NOW(a_stall_cause, clk, rst_n, $rose(pix_stall), $past(pix_valid), "input stall rose without an input word")

endmodule

bind rgb_median_filter_3x3 rmf_checker u_rmf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);

`default_nettype wire

// File: verif/tb.sv
// self-checking testbench for rgb_median_filter_3x3: apb geometry setup, pixel words in,
// median words out, checked against an in-bench line-store and window predictor
// depends on rmf_pkg and the rgb_median_filter_3x3 rtl
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import rmf_pkg::*;

    // give up well past the slowest legal run (long gaps and stalls on every word)
    localparam int unsigned CYCLE_LIMIT = 5_000_000;
    // leave room after the result pipeline before touching the registers
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_WORDS = 820;
    // words pushed under each saturated geometry
    localparam int LONG_WORDS = 400;

    // how pixel bytes are drawn
    typedef enum int {TONE_WIDE, TONE_EDGES, TONE_NARROW} tone_e;

    // predicts median words from accepted pixel words and holds them until they show up
    class median_tracker;
        bit [CFG_WIDTH_W-1:0]  width_reg;
        bit [CFG_HEIGHT_W-1:0] height_reg;
        bit [PIX_W-1:0]        upper_line [DEF_MAX_WIDTH];
        bit [PIX_W-1:0]        lower_line [DEF_MAX_WIDTH];
        bit [PIX_W-1:0]        taps [WIN_N];
        int unsigned           col_pos;
        int unsigned           row_pos;
        res_word_t             medians_due [$];
        int                    errors;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            col_pos    = 0;
            row_pos    = 0;
            errors     = 0;
            foreach (taps[i])
                taps[i] = '0;
        endfunction

        function int unsigned cols_in_use();
            if (width_reg < 3)
                return 3;
            if (width_reg > DEF_MAX_WIDTH)
                return DEF_MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned rows_in_use();
            if (height_reg < 3)
                return 3;
            if (height_reg > 4096)
                return 4096;
            return height_reg;
        endfunction

        function void flag(string msg);
            errors++;
            $error("%s", msg);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
                flag($sformatf("%s: expected %0d, actual %0d", name, want, got));
        endfunction

        // any register write restarts the raster position
        function void set_register(logic idx, logic [APB_DATA_W-1:0] value);
            if (idx == REG_IMAGE_WIDTH)
                width_reg = value[CFG_WIDTH_W-1:0];
            else
                height_reg = value[CFG_HEIGHT_W-1:0];
            col_pos = 0;
            row_pos = 0;
        endfunction

        function bit [CH_W-1:0] lane_median(int lane);
            bit [CH_W-1:0] v [WIN_N];
            bit [CH_W-1:0] x;
            int i;
            int j;
            for (i = 0; i < WIN_N; i++) begin
                x = taps[i][lane*CH_W +: CH_W];
                j = i;
                while (j > 0 && v[j-1] > x) begin
                    v[j] = v[j-1];
                    j--;
                end
                v[j] = x;
            end
            return v[WIN_N/2];
        endfunction

        function void note_pixel(pix_word_t word);
            bit [PIX_W-1:0] px;
            bit [PIX_W-1:0] up;
            bit [PIX_W-1:0] lo;
            int unsigned    wd;
            int unsigned    ht;
            int unsigned    c;
            int unsigned    r;
            int             i;
            res_word_t      m;
            wd = cols_in_use();
            ht = rows_in_use();
            px = {word.red_in, word.green_in, word.blue_in};
            if (word.frame_start) begin
                col_pos = 0;
                row_pos = 0;
            end
            c = (col_pos >= wd) ? 0 : col_pos;
            r = (row_pos >= ht) ? 0 : row_pos;
            up = upper_line[c];
            lo = lower_line[c];
            upper_line[c] = lo;
            lower_line[c] = px;
            for (i = 0; i < WIN_N; i++)
                if (i % 3 != 2)
                    taps[i] = taps[i+1];
            taps[2] = up;
            taps[5] = lo;
            taps[8] = px;
            if (c >= 2 && r >= 2) begin
                m.blue_median   = lane_median(0);
                m.green_median  = lane_median(1);
                m.red_median    = lane_median(2);
                m.centre_column = CCOL_W'(c - 1);
                m.centre_row    = CROW_W'(r - 1);
                medians_due.push_back(m);
            end
            c++;
            if (c >= wd) begin
                c = 0;
                r++;
                if (r >= ht)
                    r = 0;
            end
            col_pos = c;
            row_pos = r;
        endfunction

        function void check_result(res_word_t got);
            res_word_t want;
            if (medians_due.size() == 0) begin
                flag($sformatf("median word with none pending: column %0d row %0d",
                               got.centre_column, got.centre_row));
                return;
            end
            want = medians_due.pop_front();
            compare_field("blue_median", want.blue_median, got.blue_median);
            compare_field("green_median", want.green_median, got.green_median);
            compare_field("red_median", want.red_median, got.red_median);
            compare_field("centre_column", want.centre_column, got.centre_column);
            compare_field("centre_row", want.centre_row, got.centre_row);
        endfunction

        function int pending();
            return medians_due.size();
        endfunction
    endclass

    // clock and reset, reset held from time zero
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // apb side, idle from the start
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // pixel and median streams
    logic      pix_valid = 1'b0;
    logic      pix_stall;
    pix_word_t pix_data  = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_word_t res_data;

    median_tracker board;
    int unsigned   cycles     = 0;
    int            fed        = 0;
    int            stall_left = 0;
    // quiet flags switch off idling on a side for a whole phase
    bit            in_quiet   = 1'b0;
    bit            out_quiet  = 1'b0;

    rgb_median_filter_3x3 u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always #6 clk = ~clk;

    // watchdog
    always @(posedge clk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [CH_W-1:0] pick_byte(tone_e tone);
        case (tone)
            TONE_EDGES:
                case ($urandom_range(0, 4))
                    0:       return 8'h00;
                    1:       return 8'hff;
                    2:       return 8'h01;
                    3:       return 8'hfe;
                    default: return CH_W'($urandom);
                endcase
            // a handful of close values, lots of ties in each window
            TONE_NARROW: return CH_W'($urandom_range(100, 103));
            default:     return CH_W'($urandom);
        endcase
    endfunction

    function automatic pix_word_t make_pixel(tone_e tone, logic fs);
        pix_word_t px;
        px.blue_in     = pick_byte(tone);
        px.green_in    = pick_byte(tone);
        px.red_in      = pick_byte(tone);
        px.frame_start = fs;
        return px;
    endfunction

    // output stall: random stretches, none started while out_quiet is set
    always @(negedge clk) begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (!out_quiet && $urandom_range(0, 99) < 15) begin
            res_stall  <= 1'b1;
            stall_left <= idle_len();
        end
        else
            res_stall <= 1'b0;
    end

    // every median word taken by the bench goes to the scoreboard
    always @(posedge clk)
        if (rst_n && res_valid && !res_stall)
            board.check_result(res_data);

    task automatic apb_write(input logic idx, input logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        board.set_register(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic idx, output logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        value = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // both registers must read back what the predictor holds
    task automatic read_back();
        logic [APB_DATA_W-1:0] rd;
        apb_read(REG_IMAGE_WIDTH, rd);
        board.compare_field("image_width", board.width_reg, rd);
        apb_read(REG_IMAGE_HEIGHT, rd);
        board.compare_field("image_height", board.height_reg, rd);
    endtask

    // one pixel word; holds valid and data until taken, then maybe idles a while
    task automatic push_pixel(input pix_word_t word);
        int gap;
        @(negedge clk);
        pix_data  <= word;
        pix_valid <= 1'b1;
        do @(posedge clk); while (pix_stall);
        board.note_pixel(word);
        fed++;
        gap = (in_quiet || $urandom_range(0, 99) >= 20) ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge clk);
            pix_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // stop feeding until every predicted median has come out, plus the pipeline tail
    task automatic drain();
        @(negedge clk);
        pix_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h);
        drain();
        apb_write(REG_IMAGE_WIDTH, w);
        apb_write(REG_IMAGE_HEIGHT, h);
        read_back();
    endtask

    // one frame start on the first word, a stretch of raster behind it
    task automatic long_run(input int count);
        int p;
        for (p = 0; p < count; p++)
            push_pixel(make_pixel(tone_e'($urandom_range(0, 2)), p == 0));
    endtask

    initial begin
        pix_word_t px;
        tone_e     tone;
        int        k;
        int        p;
        int        f;
        int        w;
        int        h;
        int        r;
        int        len;
        int        frames;
        int        frame_size;
        int        start_fed;

        board = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // registers come up at 640 x 480
        read_back();

        // --- directed part ---
        // out-of-range sizes saturate to a 3x3 frame, one median per frame
        set_geometry(1, 0);
        // byte extremes: blue alternates 0 / 255, green and red ramp
        for (k = 0; k < 9; k++) begin
            px.blue_in     = k[0] ? 8'hff : 8'h00;
            px.green_in    = CH_W'(255 - k * 20);
            px.red_in      = CH_W'(k * k * 3);
            px.frame_start = (k == 0);
            push_pixel(px);
        end
        // same frame inverted, no frame start: the position wraps by itself
        for (k = 0; k < 9; k++) begin
            px.blue_in     = k[0] ? 8'h00 : 8'hff;
            px.green_in    = CH_W'(k * 20);
            px.red_in      = ~CH_W'(k * k * 3);
            px.frame_start = 1'b0;
            push_pixel(px);
        end
        // restart at column 0 of a fresh frame, then twice back to back at column 0
        push_pixel(make_pixel(TONE_WIDE, 1'b1));
        push_pixel(make_pixel(TONE_WIDE, 1'b0));
        push_pixel(make_pixel(TONE_WIDE, 1'b0));
        push_pixel(make_pixel(TONE_EDGES, 1'b1));
        push_pixel(make_pixel(TONE_EDGES, 1'b1));
        for (k = 0; k < 8; k++)
            push_pixel(make_pixel(TONE_EDGES, 1'b0));

        // widest line: width above range saturates to the full line store
        in_quiet  = 1'b1;
        out_quiet = 1'b0;
        set_geometry(4095, 3);
        long_run(LONG_WORDS);

        // tall frame: height above range saturates to 4096 rows
        in_quiet  = 1'b0;
        out_quiet = 1'b1;
        set_geometry(3, 8191);
        long_run(LONG_WORDS);

        // --- random part ---
        start_fed = fed;
        while (fed - start_fed < RANDOM_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                w = $urandom_range(3, 8);
            else if (r < 88)
                w = $urandom_range(9, 40);
            else
                w = $urandom_range(0, 2);
            r = $urandom_range(0, 99);
            if (r < 75)
                h = $urandom_range(3, 7);
            else if (r < 90)
                h = $urandom_range(8, 20);
            else
                h = $urandom_range(0, 2);
            in_quiet  = ($urandom_range(0, 3) == 0);
            out_quiet = ($urandom_range(0, 3) == 0);
            tone      = tone_e'($urandom_range(0, 2));
            set_geometry(w, h);
            frame_size = board.cols_in_use() * board.rows_in_use();
            frames     = $urandom_range(1, 4);
            for (f = 0; f < frames; f++) begin
                // most frames whole, some cut short
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, frame_size - 1)
                                                  : frame_size;
                for (p = 0; p < len && fed - start_fed < RANDOM_WORDS; p++) begin
                    // frame start on the first word mostly; a stray one now and then
                    px = make_pixel(tone, (p == 0) ? ($urandom_range(0, 9) != 0)
                                                   : ($urandom_range(0, 199) == 0));
                    push_pixel(px);
                    // sender holds off until all medians are out
                    if ($urandom_range(0, 299) == 0)
                        drain();
                end
            end
        end

        // tail: everything predicted must arrive, then nothing more
        @(negedge clk);
        pix_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4 * SETTLE_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
